[hw/rtl/odometer_trip_accumulator_assert.svh]
// assertion macros for the odometer trip accumulator checks
`ifndef ODOMETER_TRIP_ACCUMULATOR_ASSERT_SVH
`define ODOMETER_TRIP_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define OTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometer_trip_accumulator: check failed");

// next-cycle implication
`define OTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometer_trip_accumulator: check failed");

`endif

[hw/rtl/otacc_pkg.sv]
// shared types and constants of the odometer trip accumulator
package otacc_pkg;

    localparam int ODO_W  = 24;
    localparam int TRIP_W = 17;
    localparam int SLOT_W = 3;
    localparam int MODE_W = 3;
    localparam int WORD_W = 32;
    localparam int PPK_W  = 16;
    localparam int THR_W  = 34;

    localparam logic [MODE_W-1:0] MODE_IGN_ON  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INVALID = 3'd7;

    localparam logic [PPK_W-1:0] PPK_RESET = 16'd4096;

    localparam int unsigned DEF_ODO_LIMIT   = 9999999;
    localparam int unsigned DEF_TRIP_LIMIT  = 99999;
    localparam int unsigned DEF_STORE_SLOTS = 5;

    // residue units per km and per 0.1 km (24.8 frequency times ms)
    localparam int unsigned KM_SCALE = 256000;
    localparam int unsigned HM_SCALE = 25600;

    // x / 10 as (x * DIV10_MUL) >> DIV10_SHIFT, exact for 16-bit x
    localparam int unsigned DIV10_MUL   = 52429;
    localparam int unsigned DIV10_SHIFT = 19;

    typedef struct packed {
        logic              ign;
        logic              save;
        logic              rst_a;
        logic              rst_b;
        logic [WORD_W-1:0] pulses;
    } t_cmd;

    typedef struct packed {
        logic [ODO_W-1:0]  odo_km;
        logic [TRIP_W-1:0] trip_a_hm;
        logic [TRIP_W-1:0] trip_b_hm;
        logic              odo_stepped;
        logic [SLOT_W-1:0] store_slot;
        logic              save_all;
    } t_res;

endpackage

[hw/rtl/otacc_fifo.sv]
// small show-ahead queue used between the parts of the accumulator
module otacc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[hw/rtl/otacc_front.sv]
// front part: accepts ticks, tracks power mode and timing, forms pulse commands
module otacc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_power_ok,
    input  logic [otacc_pkg::MODE_W-1:0]  i_power_mode,
    input  logic [otacc_pkg::WORD_W-1:0]  i_speed_freq,
    input  logic [otacc_pkg::WORD_W-1:0]  i_time_ms,
    input  logic                          i_reset_trip_a,
    input  logic                          i_reset_trip_b,
    output logic                          o_cmd_valid,
    output otacc_pkg::t_cmd               o_cmd,
    input  logic                          i_cmd_ready
);

    import otacc_pkg::*;

    logic [WORD_W-1:0] r_prev_freq;
    logic [WORD_W-1:0] r_last_ms;
    logic [MODE_W-1:0] r_last_mode;

    logic              r_a_vld;
    logic              r_a_ign;
    logic              r_a_first;
    logic              r_a_save;
    logic              r_a_rst_a;
    logic              r_a_rst_b;
    logic [WORD_W-1:0] r_a_mean;
    logic [WORD_W-1:0] r_a_elapsed;

    logic              r_b_vld;
    t_cmd              r_b_cmd;

    logic              a_ready;
    logic              b_ready;
    logic              accept;
    logic              is_ign;
    logic [WORD_W:0]   freq_sum;
    logic [WORD_W-1:0] prod;

    assign b_ready = !r_b_vld || i_cmd_ready;
    assign a_ready = !r_a_vld || b_ready;
    assign o_full  = !a_ready;
    assign accept  = i_push && a_ready;

    assign is_ign   = i_power_ok && (i_power_mode == MODE_IGN_ON);
    assign freq_sum = {1'b0, i_speed_freq} + {1'b0, r_prev_freq};
    assign prod     = r_a_mean * r_a_elapsed;

    assign o_cmd_valid = r_b_vld;
    assign o_cmd       = r_b_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_prev_freq <= '0;
            r_last_ms   <= '0;
            r_last_mode <= MODE_INVALID;
        end else begin
            if (a_ready) begin
                r_a_vld <= accept;
            end
            if (b_ready) begin
                r_b_vld <= r_a_vld;
            end
            if (accept && i_power_ok) begin
                r_last_mode <= i_power_mode;
            end
            if (accept && is_ign) begin
                r_prev_freq <= i_speed_freq;
                r_last_ms   <= i_time_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_ign     <= is_ign;
            r_a_first   <= (r_last_mode != MODE_IGN_ON);
            r_a_save    <= i_power_ok && (i_power_mode != r_last_mode)
                           && (i_power_mode != MODE_IGN_ON);
            r_a_rst_a   <= i_reset_trip_a;
            r_a_rst_b   <= i_reset_trip_b;
            r_a_mean    <= freq_sum[WORD_W:1];
            r_a_elapsed <= i_time_ms - r_last_ms;
        end
        if (b_ready && r_a_vld) begin
            r_b_cmd.ign    <= r_a_ign;
            r_b_cmd.save   <= r_a_save;
            r_b_cmd.rst_a  <= r_a_rst_a;
            r_b_cmd.rst_b  <= r_a_rst_b;
            r_b_cmd.pulses <= r_a_first ? '0 : prod;
        end
    end

endmodule

[hw/rtl/otacc_back.sv]
// back part: applies pulse commands to the odometer, trips and store slot
module otacc_back #(
    parameter int unsigned ODO_LIMIT   = otacc_pkg::DEF_ODO_LIMIT,
    parameter int unsigned TRIP_LIMIT  = otacc_pkg::DEF_TRIP_LIMIT,
    parameter int unsigned STORE_SLOTS = otacc_pkg::DEF_STORE_SLOTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [otacc_pkg::PPK_W-1:0]  i_cfg_data,
    input  logic                         i_cmd_valid,
    input  otacc_pkg::t_cmd              i_cmd,
    output logic                         o_cmd_pop,
    input  logic                         i_res_ready,
    output logic                         o_res_push,
    output otacc_pkg::t_res              o_res
);

    import otacc_pkg::*;

    typedef struct packed {
        logic [TRIP_W-1:0] value;
        logic [WORD_W-1:0] residue;
    } t_trip;

    localparam logic [THR_W-1:0]  ODO_THR_RST  =
        THR_W'((64'(PPK_RESET) + 64'd1) * 64'(KM_SCALE));
    localparam logic [WORD_W-1:0] ODO_SUB_RST  =
        WORD_W'(64'(PPK_RESET) * 64'(KM_SCALE));
    localparam logic [PPK_W-1:0]  TRIP_T_RST   = PPK_W'(PPK_RESET / 10);
    localparam logic [THR_W-1:0]  TRIP_THR_RST =
        THR_W'((64'(TRIP_T_RST) + 64'd1) * 64'(KM_SCALE));
    localparam logic [WORD_W-1:0] TRIP_SUB_RST =
        WORD_W'(64'(PPK_RESET) * 64'(HM_SCALE));

    function automatic t_trip trip_step(
        input logic [TRIP_W-1:0] value,
        input logic [WORD_W-1:0] residue,
        input logic              clear,
        input logic [WORD_W-1:0] pulses,
        input logic [THR_W-1:0]  thr,
        input logic [WORD_W-1:0] sub
    );
        t_trip             res;
        logic [WORD_W-1:0] sum;
        res.value   = value;
        res.residue = residue;
        sum         = residue + pulses;
        if (clear) begin
            res.value   = '0;
            res.residue = '0;
        end else if (value < TRIP_W'(TRIP_LIMIT)) begin
            if ({{(THR_W-WORD_W){1'b0}}, sum} >= thr) begin
                res.value   = value + 1'b1;
                res.residue = sum - sub;
            end else begin
                res.residue = sum;
            end
        end
        return res;
    endfunction

    logic [PPK_W-1:0]  r_ppk;
    logic [THR_W-1:0]  r_odo_thr;
    logic [WORD_W-1:0] r_odo_sub;
    logic [PPK_W-1:0]  r_trip_t;
    logic [THR_W-1:0]  r_trip_thr;
    logic [WORD_W-1:0] r_trip_sub;

    logic [ODO_W-1:0]  r_odo;
    logic [WORD_W-1:0] r_odo_res;
    logic [TRIP_W-1:0] r_trip_a;
    logic [WORD_W-1:0] r_trip_a_res;
    logic [TRIP_W-1:0] r_trip_b;
    logic [WORD_W-1:0] r_trip_b_res;
    logic [SLOT_W-1:0] r_slot;
    logic              r_pend_a;
    logic              r_pend_b;

    logic [ODO_W-1:0]  n_odo;
    logic [WORD_W-1:0] n_odo_res;
    logic [SLOT_W-1:0] n_slot;
    logic              n_pend_a;
    logic              n_pend_b;
    t_trip             n_trip_a;
    t_trip             n_trip_b;

    logic              step_go;
    logic              pend_a;
    logic              pend_b;
    logic [WORD_W-1:0] odo_sum;
    logic              odo_run;
    logic              odo_hit;
    logic              stepped;

    assign o_cfg_ready = 1'b1;
    assign step_go     = i_cmd_valid && i_res_ready;
    assign o_cmd_pop   = step_go;
    assign o_res_push  = step_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppk      <= PPK_RESET;
            r_odo_thr  <= ODO_THR_RST;
            r_odo_sub  <= ODO_SUB_RST;
            r_trip_t   <= TRIP_T_RST;
            r_trip_thr <= TRIP_THR_RST;
            r_trip_sub <= TRIP_SUB_RST;
        end else begin
            if (i_cfg_valid) begin
                r_ppk <= i_cfg_data;
            end
            r_odo_thr  <= (THR_W'(r_ppk) + 1'b1) * THR_W'(KM_SCALE);
            r_odo_sub  <= WORD_W'(r_ppk) * WORD_W'(KM_SCALE);
            r_trip_t   <= PPK_W'((WORD_W'(r_ppk) * WORD_W'(DIV10_MUL)) >> DIV10_SHIFT);
            r_trip_thr <= (THR_W'(r_trip_t) + 1'b1) * THR_W'(KM_SCALE);
            r_trip_sub <= WORD_W'(r_ppk) * WORD_W'(HM_SCALE);
        end
    end

    always_comb begin
        pend_a  = r_pend_a || i_cmd.rst_a;
        pend_b  = r_pend_b || i_cmd.rst_b;
        odo_sum = r_odo_res + i_cmd.pulses;
        odo_run = i_cmd.ign && (r_odo < ODO_W'(ODO_LIMIT));
        odo_hit = ({{(THR_W-WORD_W){1'b0}}, odo_sum} >= r_odo_thr);
        stepped = odo_run && odo_hit;

        n_odo     = r_odo;
        n_odo_res = r_odo_res;
        n_slot    = r_slot;
        if (odo_run) begin
            n_odo_res = odo_hit ? odo_sum - r_odo_sub : odo_sum;
        end
        if (stepped) begin
            n_odo  = r_odo + 1'b1;
            n_slot = (r_slot >= SLOT_W'(STORE_SLOTS - 1)) ? '0 : r_slot + 1'b1;
        end

        n_trip_a.value   = r_trip_a;
        n_trip_a.residue = r_trip_a_res;
        n_trip_b.value   = r_trip_b;
        n_trip_b.residue = r_trip_b_res;
        n_pend_a         = pend_a;
        n_pend_b         = pend_b;
        if (i_cmd.ign) begin
            n_trip_a = trip_step(r_trip_a, r_trip_a_res, pend_a, i_cmd.pulses,
                                 r_trip_thr, r_trip_sub);
            n_trip_b = trip_step(r_trip_b, r_trip_b_res, pend_b, i_cmd.pulses,
                                 r_trip_thr, r_trip_sub);
            n_pend_a = 1'b0;
            n_pend_b = 1'b0;
        end

        o_res.odo_km      = n_odo;
        o_res.trip_a_hm   = n_trip_a.value;
        o_res.trip_b_hm   = n_trip_b.value;
        o_res.odo_stepped = stepped;
        o_res.store_slot  = stepped ? r_slot : '0;
        o_res.save_all    = i_cmd.save;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odo        <= '0;
            r_odo_res    <= '0;
            r_trip_a     <= '0;
            r_trip_a_res <= '0;
            r_trip_b     <= '0;
            r_trip_b_res <= '0;
            r_slot       <= '0;
            r_pend_a     <= 1'b0;
            r_pend_b     <= 1'b0;
        end else if (step_go) begin
            r_odo        <= n_odo;
            r_odo_res    <= n_odo_res;
            r_trip_a     <= n_trip_a.value;
            r_trip_a_res <= n_trip_a.residue;
            r_trip_b     <= n_trip_b.value;
            r_trip_b_res <= n_trip_b.residue;
            r_slot       <= n_slot;
            r_pend_a     <= n_pend_a;
            r_pend_b     <= n_pend_b;
        end
    end

endmodule

[hw/rtl/odometer_trip_accumulator.sv]
// Odometer and trip accumulator, top level. One tick item enters per clock while
// full is low and one result item leaves per clock while pop is high and empty is
// low. A tick passes the two front stages (frequency mean and elapsed time, then
// the 32 x 32 pulse multiply), the two-entry command queue and the back stage that
// updates odometer, trips and store slot together, before its result shows
// (empty low). The two-entry result queue lets the front keep accepting while a
// result waits. Configuration writes are always ready; the derived km and 0.1 km
// thresholds are registered from r_ppk before any later tick reaches them.
module odometer_trip_accumulator #(
    parameter int unsigned ODO_LIMIT   = otacc_pkg::DEF_ODO_LIMIT,
    parameter int unsigned TRIP_LIMIT  = otacc_pkg::DEF_TRIP_LIMIT,
    parameter int unsigned STORE_SLOTS = otacc_pkg::DEF_STORE_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [otacc_pkg::PPK_W-1:0]   i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_power_ok,
    input  logic [otacc_pkg::MODE_W-1:0]  i_power_mode,
    input  logic [otacc_pkg::WORD_W-1:0]  i_speed_freq,
    input  logic [otacc_pkg::WORD_W-1:0]  i_time_ms,
    input  logic                          i_reset_trip_a,
    input  logic                          i_reset_trip_b,
    output logic                          empty,
    input  logic                          pop,
    output logic [otacc_pkg::ODO_W-1:0]   o_odo_km,
    output logic [otacc_pkg::TRIP_W-1:0]  o_trip_a_hm,
    output logic [otacc_pkg::TRIP_W-1:0]  o_trip_b_hm,
    output logic                          o_odo_stepped,
    output logic [otacc_pkg::SLOT_W-1:0]  o_store_slot,
    output logic                          o_save_all
);

    import otacc_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    logic fr_cmd_valid;
    t_cmd fr_cmd;
    logic cq_full;
    logic cq_empty;
    t_cmd cq_cmd;
    logic bk_cmd_pop;
    logic bk_res_push;
    t_res bk_res;
    logic rq_full;
    t_res rq_res;

    otacc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_power_ok     (i_power_ok),
        .i_power_mode   (i_power_mode),
        .i_speed_freq   (i_speed_freq),
        .i_time_ms      (i_time_ms),
        .i_reset_trip_a (i_reset_trip_a),
        .i_reset_trip_b (i_reset_trip_b),
        .o_cmd_valid    (fr_cmd_valid),
        .o_cmd          (fr_cmd),
        .i_cmd_ready    (!cq_full)
    );

    otacc_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_cmd_valid),
        .i_data  (fr_cmd),
        .o_full  (cq_full),
        .i_pop   (bk_cmd_pop),
        .o_data  (cq_cmd),
        .o_empty (cq_empty)
    );

    otacc_back #(
        .ODO_LIMIT   (ODO_LIMIT),
        .TRIP_LIMIT  (TRIP_LIMIT),
        .STORE_SLOTS (STORE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!cq_empty),
        .i_cmd       (cq_cmd),
        .o_cmd_pop   (bk_cmd_pop),
        .i_res_ready (!rq_full),
        .o_res_push  (bk_res_push),
        .o_res       (bk_res)
    );

    otacc_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_res_push),
        .i_data  (bk_res),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_res),
        .o_empty (empty)
    );

    assign o_odo_km      = rq_res.odo_km;
    assign o_trip_a_hm   = rq_res.trip_a_hm;
    assign o_trip_b_hm   = rq_res.trip_b_hm;
    assign o_odo_stepped = rq_res.odo_stepped;
    assign o_store_slot  = rq_res.store_slot;
    assign o_save_all    = rq_res.save_all;

endmodule

[hw/rtl/otacc_checker.sv]
// port-level checks for the odometer trip accumulator, bound to the top level
`include "odometer_trip_accumulator_assert.svh"

module otacc_checker #(
    parameter int unsigned ODO_LIMIT   = otacc_pkg::DEF_ODO_LIMIT,
    parameter int unsigned TRIP_LIMIT  = otacc_pkg::DEF_TRIP_LIMIT,
    parameter int unsigned STORE_SLOTS = otacc_pkg::DEF_STORE_SLOTS
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_empty,
    input logic                          i_pop,
    input logic [otacc_pkg::ODO_W-1:0]   i_odo_km,
    input logic [otacc_pkg::TRIP_W-1:0]  i_trip_a_hm,
    input logic [otacc_pkg::TRIP_W-1:0]  i_trip_b_hm,
    input logic                          i_odo_stepped,
    input logic [otacc_pkg::SLOT_W-1:0]  i_store_slot
);

    import otacc_pkg::*;

    `OTA_ASSERT_NOW(a_odo_limit, i_clk, i_rst_n, !i_empty,
        32'(i_odo_km) <= ODO_LIMIT)

    `OTA_ASSERT_NOW(a_trip_limit, i_clk, i_rst_n, !i_empty,
        (32'(i_trip_a_hm) <= TRIP_LIMIT) && (32'(i_trip_b_hm) <= TRIP_LIMIT))

    `OTA_ASSERT_NOW(a_slot_range, i_clk, i_rst_n, !i_empty,
        i_odo_stepped ? (32'(i_store_slot) < STORE_SLOTS) : (i_store_slot == '0))

    `OTA_ASSERT_NEXT(a_odo_monotonic, i_clk, i_rst_n, !i_empty && i_pop,
        i_empty || (i_odo_km >= $past(i_odo_km)))

    `OTA_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !i_empty && !i_pop,
        !i_empty && $stable(i_odo_km) && $stable(i_store_slot))

endmodule

bind odometer_trip_accumulator otacc_checker #(
    .ODO_LIMIT   (ODO_LIMIT),
    .TRIP_LIMIT  (TRIP_LIMIT),
    .STORE_SLOTS (STORE_SLOTS)
) u_otacc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_empty       (empty),
    .i_pop         (pop),
    .i_odo_km      (o_odo_km),
    .i_trip_a_hm   (o_trip_a_hm),
    .i_trip_b_hm   (o_trip_b_hm),
    .i_odo_stepped (o_odo_stepped),
    .i_store_slot  (o_store_slot)
);
